@@ sv/rpfc_pkg.sv @@
// Package for the RF pulse frame capture block: sizes, register codes,
// request and result structs, and the sequencer state type.
// Depends on nothing; the capture block and its testbench import it.
package rpfc_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	localparam int TIME_W  = 16;
	localparam int FIELD_W = 7;
	localparam int CFG_W   = 2;

	localparam logic [TIME_W-1:0] GAP_THRESHOLD_RST = 16'd8000;
	localparam logic [TIME_W-1:0] MAX_PULSE_RST     = 16'd16000;

	localparam logic [CFG_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
	localparam logic [CFG_W-1:0] CFG_MAX_PULSE     = 2'd1;

	localparam logic ACT_CAPTURE = 1'b0;
	localparam logic ACT_READ    = 1'b1;

	localparam logic STATUS_DELIVERED = 1'b0;
	localparam logic STATUS_NO_FRAME  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [TIME_W-1:0]  capture_time;
		logic [FIELD_W-1:0] read_limit;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [TIME_W-1:0]  pulse_duration;
		logic               pulse_level;
		logic               pulse_valid;
		logic [FIELD_W-1:0] frame_count;
		logic               last;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

endpackage

@@ sv/rpfc_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; used for the pulse store of the capture block.
module rpfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// The read data holds until the next read is issued.
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/rf_pulse_frame_capture.sv @@
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_stall    | item_t (action, time, read_limit)
// result   | out       | result_valid / result_stall| result_t (one per pulse, or one per empty read)
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A capture is handled as it is taken: the duration is worked out and, if it counts as a pulse,
// written to the pulse store in the cycle the request is taken. A read without a frame,
// or with nothing to deliver, gives its single result in the next cycle. A read
// of n pulses streams one pulse per cycle from the registered store read while
// results are not stalled, and no request is taken until its last result is
// registered. Reset clears the control state and the counters; the store
// itself is not cleared. A stalled result holds, and the stream pauses.
// Depends on rpfc_pkg and rpfc_ram.
module rf_pulse_frame_capture
	import rpfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [TIME_W-1:0] gap_threshold_q;
	logic [TIME_W-1:0] max_pulse_q;
	logic [TIME_W-1:0] prev_time_q;
	logic [CNT_W-1:0]  pulse_count_q;
	logic              capturing_q;
	logic              frame_done_q;

	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  n_q;
	logic              valid_s1;
	logic              level_s1;
	logic              last_s1;

	logic              res_valid_q;
	result_t           res_q;

	logic              streaming;
	logic              item_take;
	logic              cap_take;
	logic              read_take;

	logic [TIME_W-1:0] dur;
	logic              cap_write;
	logic [CNT_W-1:0]  base_count;
	logic [CNT_W-1:0]  mc_clamp;
	logic [CNT_W-1:0]  n_calc;
	logic              read_stream;
	logic              read_single;

	logic              load_s1;
	logic              issue;
	logic [TIME_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	assign item_take = item_valid && !item_stall;
	assign cap_take  = item_take && (item.action == ACT_CAPTURE);
	assign read_take = item_take && (item.action == ACT_READ);

	// Capture path.
	assign dur        = item.capture_time - prev_time_q;
	assign base_count = capturing_q ? pulse_count_q : '0;
	assign cap_write  = cap_take && (dur != '0) && (dur <= gap_threshold_q)
		&& (dur <= max_pulse_q) && (base_count < CNT_W'(BUFFER_DEPTH));

	// Read sizing: requests above the store depth are clamped to it.
	always_comb begin
		if (item.read_limit > FIELD_W'(BUFFER_DEPTH)) begin
			mc_clamp = CNT_W'(BUFFER_DEPTH);
		end else begin
			mc_clamp = CNT_W'(item.read_limit);
		end
		n_calc = (pulse_count_q > mc_clamp) ? mc_clamp : pulse_count_q;
	end

	assign read_stream = read_take && frame_done_q && (n_calc != '0);
	assign read_single = read_take && !read_stream;

	// Stream control: a read is issued whenever the stage after the RAM will
	// be free, so pulses flow one per cycle while the result side is open.
	assign load_s1 = valid_s1 && (!res_valid_q || !result_stall);
	assign issue   = streaming && (rd_idx_q < n_q) && (!valid_s1 || load_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (read_stream) begin
					state_d = ST_STREAM;
				end
			end
			ST_STREAM: begin
				if (load_s1 && last_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		streaming  = (state_q == ST_STREAM);
		item_stall = streaming || (res_valid_q && result_stall);
	end

	rpfc_ram #(
		.WIDTH(TIME_W),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (cap_write),
		.wr_addr(base_count[IDX_W-1:0]),
		.wr_data(dur),
		.rd_en  (issue),
		.rd_addr(rd_idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			gap_threshold_q <= GAP_THRESHOLD_RST;
			max_pulse_q     <= MAX_PULSE_RST;
			prev_time_q     <= '0;
			pulse_count_q   <= '0;
			capturing_q     <= 1'b0;
			frame_done_q    <= 1'b0;
			rd_idx_q        <= '0;
			n_q             <= '0;
			valid_s1        <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_GAP_THRESHOLD: gap_threshold_q <= cfg_data;
					CFG_MAX_PULSE:     max_pulse_q     <= cfg_data;
					default: ;
				endcase
			end

			if (cap_take) begin
				prev_time_q <= item.capture_time;
				if (dur != '0) begin
					if (dur > gap_threshold_q) begin
						if (pulse_count_q != '0) begin
							frame_done_q <= 1'b1;
						end
						capturing_q <= 1'b0;
					end else if (dur <= max_pulse_q) begin
						capturing_q <= 1'b1;
						if (base_count < CNT_W'(BUFFER_DEPTH)) begin
							pulse_count_q <= base_count + CNT_W'(1);
						end else begin
							pulse_count_q <= base_count;
						end
					end
				end
			end

			// A read clears the frame as it is taken; the stream works from n_q.
			if (read_take && frame_done_q) begin
				pulse_count_q <= '0;
				frame_done_q  <= 1'b0;
				capturing_q   <= 1'b0;
			end

			if (read_stream) begin
				rd_idx_q <= '0;
				n_q      <= n_calc;
				valid_s1 <= 1'b0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
				valid_s1 <= 1'b1;
			end else if (load_s1) begin
				valid_s1 <= 1'b0;
			end

			if (read_single || load_s1) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Position metadata travels alongside the RAM read.
	always_ff @(posedge clk) begin
		if (issue) begin
			level_s1 <= ~rd_idx_q[0];
			last_s1  <= (rd_idx_q + CNT_W'(1)) == n_q;
		end
	end

	always_ff @(posedge clk) begin
		if (read_single) begin
			res_q.status         <= frame_done_q ? STATUS_DELIVERED : STATUS_NO_FRAME;
			res_q.pulse_duration <= '0;
			res_q.pulse_level    <= 1'b0;
			res_q.pulse_valid    <= 1'b0;
			res_q.frame_count    <= '0;
			res_q.last           <= 1'b1;
		end else if (load_s1) begin
			res_q.status         <= STATUS_DELIVERED;
			res_q.pulse_duration <= rd_data;
			res_q.pulse_level    <= level_s1;
			res_q.pulse_valid    <= 1'b1;
			res_q.frame_count    <= FIELD_W'(n_q);
			res_q.last           <= last_s1;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for rf_pulse_frame_capture: edge captures and frame reads
// are driven from a request queue, predicted in step, and checked against the results.
// Depends on rpfc_pkg and the block's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rpfc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	item_t             item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_index    = '0;
	logic [TIME_W-1:0] cfg_data     = '0;

	rf_pulse_frame_capture dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted copy of the block's registers and frame state.
	logic [TIME_W-1:0] gap_cfg    = GAP_THRESHOLD_RST;
	logic [TIME_W-1:0] max_cfg    = MAX_PULSE_RST;
	logic [TIME_W-1:0] last_stamp = '0;
	int                held       = 0;
	bit                in_frame   = 1'b0;
	bit                frame_closed = 1'b0;
	logic [TIME_W-1:0] pulse_mem [BUFFER_DEPTH];

	item_t   queued_requests [$];
	result_t read_results_due [$];

	int items_queued   = 0;
	int items_accepted = 0;
	int results_taken  = 0;
	int mismatches     = 0;
	int cycles         = 0;
	int phase_id       = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	// Timestamp of the last capture queued, which mirrors the block's previous edge.
	logic [TIME_W-1:0] stamp_gen = '0;

	result_t want_r;

	task automatic model_pulse_frame(input item_t it);
		logic [TIME_W-1:0] dur;
		int lim;
		int n;
		result_t r;
		if (it.action == ACT_CAPTURE) begin
			dur = it.capture_time - last_stamp;
			last_stamp = it.capture_time;
			if (dur == 0)
				return;
			if (dur > gap_cfg) begin
				if (held > 0)
					frame_closed = 1'b1;
				in_frame = 1'b0;
				return;
			end
			if (dur > max_cfg)
				return;
			if (!in_frame) begin
				held = 0;
				in_frame = 1'b1;
			end
			if (held < BUFFER_DEPTH) begin
				pulse_mem[held] = dur;
				held++;
			end
		end else begin
			r = '0;
			r.last = 1'b1;
			if (!frame_closed) begin
				r.status = STATUS_NO_FRAME;
				read_results_due.push_back(r);
				return;
			end
			lim = (it.read_limit > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(it.read_limit);
			n = (held < lim) ? held : lim;
			r.status = STATUS_DELIVERED;
			if (n == 0)
				read_results_due.push_back(r);
			for (int i = 0; i < n; i++) begin
				r.pulse_duration = pulse_mem[i];
				r.pulse_level    = (i % 2 == 0);
				r.pulse_valid    = 1'b1;
				r.frame_count    = FIELD_W'(n);
				r.last           = (i + 1 == n);
				read_results_due.push_back(r);
			end
			held = 0;
			frame_closed = 1'b0;
			in_frame = 1'b0;
		end
	endtask

	// Driver: a new request is presented only once the previous one has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				model_pulse_frame(item);
				items_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= queued_requests.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_taken++;
				if (read_results_due.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $time, result);
					mismatches++;
				end else begin
					want_r = read_results_due.pop_front();
					if (result !== want_r) begin
						$display("%0t: result expected %p, actual %p", $time, want_r, result);
						mismatches++;
					end
				end
			end
		end
	end

	// Receiver stall, with one long hold-off early on so that the block backs up
	// onto its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && phase_id == 0 && results_taken >= 12) begin
				result_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [TIME_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_GAP_THRESHOLD)
			gap_cfg = val;
		else if (idx == CFG_MAX_PULSE)
			max_cfg = val;
	endtask

	task automatic queue_capture(input logic [TIME_W-1:0] stamp);
		item_t it;
		it.action       = ACT_CAPTURE;
		it.capture_time = stamp;
		it.read_limit   = FIELD_W'($urandom_range(127, 0));
		queued_requests.push_back(it);
		items_queued++;
		stamp_gen = stamp;
	endtask

	task automatic queue_pulse(input logic [TIME_W-1:0] dur);
		queue_capture(stamp_gen + dur);
	endtask

	task automatic queue_read(input int mc);
		item_t it;
		it.action       = ACT_READ;
		it.capture_time = TIME_W'($urandom_range(65535, 0));
		it.read_limit   = FIELD_W'(mc);
		queued_requests.push_back(it);
		items_queued++;
	endtask

	function automatic logic [TIME_W-1:0] valid_dur();
		int lim;
		lim = (gap_cfg < max_cfg) ? int'(gap_cfg) : int'(max_cfg);
		if (lim == 0)
			return TIME_W'($urandom_range(65535, 1));
		return TIME_W'($urandom_range(lim, 1));
	endfunction

	function automatic logic [TIME_W-1:0] gap_dur();
		if (gap_cfg == 16'hFFFF)
			return TIME_W'($urandom_range(65535, 1));
		return TIME_W'($urandom_range(65535, int'(gap_cfg) + 1));
	endfunction

	// Durations over the pulse limit but within the gap, where any exist.
	function automatic logic [TIME_W-1:0] dropped_dur();
		if (max_cfg < gap_cfg)
			return TIME_W'($urandom_range(int'(gap_cfg), int'(max_cfg) + 1));
		return TIME_W'($urandom_range(65535, 1));
	endfunction

	// A frame of pulses with some noise mixed in, normally closed by a gap and read back.
	task automatic queue_frame();
		int len;
		int roll;
		int mc;
		roll = $urandom_range(99);
		len = (roll < 8) ? $urandom_range(72, 60) : $urandom_range(12, 1);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (roll < 82)
				queue_pulse(valid_dur());
			else if (roll < 88)
				queue_pulse('0);
			else if (roll < 94)
				queue_pulse(dropped_dur());
			else
				queue_capture(TIME_W'($urandom_range(65535, 0)));
		end
		if ($urandom_range(99) < 90)
			queue_pulse(gap_dur());
		if ($urandom_range(99) < 10)
			queue_pulse(valid_dur());
		roll = $urandom_range(99);
		if (roll < 55)
			mc = $urandom_range(127, 64);
		else if (roll < 80)
			mc = $urandom_range(len, 1);
		else if (roll < 88)
			mc = 0;
		else
			mc = $urandom_range(127, 0);
		queue_read(mc);
		if ($urandom_range(99) < 10)
			queue_read($urandom_range(127, 0));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (items_accepted != items_queued || read_results_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int id, input int budget, input int idle, input int stall);
		int start;
		phase_id = id;
		send_idle_pct = idle;
		stall_pct = stall;
		start = items_queued;
		@(negedge clk);
		while (items_queued - start < budget)
			queue_frame();
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests under the reset settings.
		queue_read(0);
		queue_capture(16'd0);
		queue_capture(16'd65535);
		queue_capture(16'd0);
		queue_capture(16'd8000);
		queue_capture(16'd8000);
		queue_pulse(16'd8001);
		queue_read(127);
		queue_read(64);
		// A capture after the frame is ready starts a new one; the read sees only that.
		queue_pulse(16'd100);
		queue_pulse(16'd200);
		queue_pulse(16'd9000);
		queue_pulse(16'd50);
		queue_read(64);
		queue_pulse(16'd10);
		queue_pulse(16'd20);
		queue_pulse(16'd30);
		queue_pulse(16'd65535);
		queue_read(1);
		queue_pulse(16'd7);
		queue_pulse(16'd9000);
		queue_read(0);

		run_phase(0, 70, 0, 0);

		write_reg(CFG_GAP_THRESHOLD, 16'd1000);
		write_reg(CFG_MAX_PULSE, 16'd600);
		run_phase(1, 70, 52, 0);

		// No duration can exceed these, so frames never close.
		write_reg(CFG_GAP_THRESHOLD, 16'hFFFF);
		write_reg(CFG_MAX_PULSE, 16'hFFFF);
		run_phase(2, 40, 0, 52);

		write_reg(CFG_SPARE, 16'h5A5A);
		write_reg(CFG_GAP_THRESHOLD, 16'd0);
		write_reg(CFG_MAX_PULSE, 16'd0);
		run_phase(3, 25, 18, 18);

		write_reg(CFG_GAP_THRESHOLD, 16'd40000);
		write_reg(CFG_MAX_PULSE, 16'd20000);
		run_phase(4, 85, 52, 0);

		write_reg(CFG_GAP_THRESHOLD, 16'd300);
		write_reg(CFG_MAX_PULSE, 16'hFFFF);
		run_phase(5, 75, 0, 52);

		write_reg(CFG_GAP_THRESHOLD, 16'd5000);
		write_reg(CFG_MAX_PULSE, 16'd2500);
		run_phase(6, 50, 18, 18);

		if (mismatches == 0 && read_results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rpfc_pkg.sv
sv/rpfc_ram.sv
sv/rf_pulse_frame_capture.sv
sim/tb_top.sv
